// ===== hw/rtl/imupm_pkg.sv =====
// ----------------------------------------------------------------------------
// imupm_pkg
// Shared types and constants of the IMU moving-average power monitor: the
// sequencer phases, the control bundle sent to the axis lanes and the
// configuration register map with its reset values.
// ----------------------------------------------------------------------------
package imupm_pkg;

  localparam int AXES      = 6;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 32;
  localparam int ALPHA_W   = 16;
  localparam int ALPHA_FRAC = 16;
  localparam int TOL_W     = 32;
  localparam int INTV_W    = 16;
  localparam int TICK_W    = 32;
  localparam int POWER_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_TOLERANCE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MIN    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MAX    = 8'd3;

  localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST       = 16'd1966;
  localparam logic [TOL_W-1:0]   POWER_TOLERANCE_RST = 32'd19661;
  localparam logic [INTV_W-1:0]  INTERVAL_MIN_RST    = 16'd9;
  localparam logic [INTV_W-1:0]  INTERVAL_MAX_RST    = 16'd11;

  // Lane axis order: gyro x, y, z then accel x, y, z.
  localparam int AX_GYRO_X  = 0;
  localparam int AX_GYRO_Y  = 1;
  localparam int AX_GYRO_Z  = 2;
  localparam int AX_ACCEL_X = 3;
  localparam int AX_ACCEL_Y = 4;
  localparam int AX_ACCEL_Z = 5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_EMA,
    PH_RAW,
    PH_FILT,
    PH_SUM,
    PH_CMP
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   load;
    logic   primed;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/imupm_if.sv =====
// ----------------------------------------------------------------------------
// imupm interfaces
// Valid/ready channels of the monitor: the sample channel, the result channel
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface imupm_sample_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] gyro_x;
  logic signed [SAMPLE_WIDTH-1:0] gyro_y;
  logic signed [SAMPLE_WIDTH-1:0] gyro_z;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  logic [imupm_pkg::TICK_W-1:0]   sample_tick;

  modport source(output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                 sample_tick, input ready);
  modport sink(input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
               sample_tick, output ready);
endinterface

interface imupm_result_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] mean_gyro_x;
  logic signed [SAMPLE_WIDTH-1:0] mean_gyro_y;
  logic signed [SAMPLE_WIDTH-1:0] mean_gyro_z;
  logic signed [SAMPLE_WIDTH-1:0] mean_accel_x;
  logic signed [SAMPLE_WIDTH-1:0] mean_accel_y;
  logic signed [SAMPLE_WIDTH-1:0] mean_accel_z;
  logic [imupm_pkg::POWER_W-1:0]  accel_power;
  logic [imupm_pkg::POWER_W-1:0]  gyro_power;
  logic                           accel_power_error;
  logic                           gyro_power_error;
  logic                           interval_error;
  logic [imupm_pkg::INTV_W-1:0]   sample_interval;

  modport source(output valid, mean_gyro_x, mean_gyro_y, mean_gyro_z, mean_accel_x,
                 mean_accel_y, mean_accel_z, accel_power, gyro_power,
                 accel_power_error, gyro_power_error, interval_error,
                 sample_interval, input ready);
  modport sink(input valid, mean_gyro_x, mean_gyro_y, mean_gyro_z, mean_accel_x,
               mean_accel_y, mean_accel_z, accel_power, gyro_power,
               accel_power_error, gyro_power_error, interval_error,
               sample_interval, output ready);
endinterface

interface imupm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [imupm_pkg::CFG_IDX_W-1:0] index;
  logic [imupm_pkg::CFG_DAT_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/imu_ema_power_monitor.sv =====
// ----------------------------------------------------------------------------
// imu_ema_power_monitor
// Six-axis moving-average filter with sensor power and tick-interval checks.
// ----------------------------------------------------------------------------
// Each accepted beat carries one gyro/accel sample and its tick count and
// yields one result beat with the six updated means, the filtered power of
// each sensor, the raw-versus-filtered power error flags and the tick
// interval check. Six lanes, one per axis, each own one multiplier that is
// used in three successive phases (smoothing product, raw square, filtered
// square); a merging stage then sums in the SUM phase and compares in the CMP
// phase, from which the result is loaded into the output register once that
// register is free. A new sample is not taken before that result is registered,
// but is taken once it is, even while the result still waits on the result
// channel. The first sample after reset loads the means directly and reports
// an interval of zero.
module imu_ema_power_monitor #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  imupm_sample_if.sink          in_ch,
  imupm_result_if.source        out_ch,
  imupm_cfg_if.sink             cfg_ch
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int SQW = 2 * SW;
  localparam int NAX = imupm_pkg::AXES;

  imupm_pkg::phase_t phase_r;
  imupm_pkg::phase_t phase_nxt;
  imupm_pkg::lane_ctl_t lane_ctl;

  logic [imupm_pkg::ALPHA_W-1:0] alpha_r;
  logic [imupm_pkg::TOL_W-1:0]   tol_r;
  logic [imupm_pkg::INTV_W-1:0]  imin_r;
  logic [imupm_pkg::INTV_W-1:0]  imax_r;
  logic [imupm_pkg::TICK_W-1:0]  prev_tick_r;
  logic                          primed_r;
  logic [imupm_pkg::INTV_W-1:0]  intv_r;
  logic [imupm_pkg::INTV_W-1:0]  intv_nxt;
  logic                          ierr_r;
  logic                          ierr_nxt;
  logic [imupm_pkg::TICK_W-1:0]  tick_diff;

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          out_load;
  logic                          out_valid_r;

  logic signed [SW-1:0]          lane_in   [NAX];
  logic signed [SW-1:0]          lane_mean [NAX];
  logic [SQW-1:0]                lane_raw  [NAX];
  logic [SQW-1:0]                lane_filt [NAX];

  logic [imupm_pkg::POWER_W-1:0] m_accel_power;
  logic [imupm_pkg::POWER_W-1:0] m_gyro_power;
  logic                          m_accel_err;
  logic                          m_gyro_err;

  logic signed [SW-1:0]          o_mean_r [NAX];
  logic [imupm_pkg::POWER_W-1:0] o_accel_power_r;
  logic [imupm_pkg::POWER_W-1:0] o_gyro_power_r;
  logic                          o_accel_err_r;
  logic                          o_gyro_err_r;
  logic                          o_ierr_r;
  logic [imupm_pkg::INTV_W-1:0]  o_intv_r;

  assign in_ch.ready  = (phase_r == imupm_pkg::PH_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;
  assign out_load     = (phase_r == imupm_pkg::PH_CMP) && (!out_valid_r || out_ch.ready);

  assign lane_in[imupm_pkg::AX_GYRO_X]  = in_ch.gyro_x;
  assign lane_in[imupm_pkg::AX_GYRO_Y]  = in_ch.gyro_y;
  assign lane_in[imupm_pkg::AX_GYRO_Z]  = in_ch.gyro_z;
  assign lane_in[imupm_pkg::AX_ACCEL_X] = in_ch.accel_x;
  assign lane_in[imupm_pkg::AX_ACCEL_Y] = in_ch.accel_y;
  assign lane_in[imupm_pkg::AX_ACCEL_Z] = in_ch.accel_z;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      imupm_pkg::PH_IDLE: begin
        if (in_fire) begin
          phase_nxt = imupm_pkg::PH_EMA;
        end
      end
      imupm_pkg::PH_EMA:  phase_nxt = imupm_pkg::PH_RAW;
      imupm_pkg::PH_RAW:  phase_nxt = imupm_pkg::PH_FILT;
      imupm_pkg::PH_FILT: phase_nxt = imupm_pkg::PH_SUM;
      imupm_pkg::PH_SUM:  phase_nxt = imupm_pkg::PH_CMP;
      imupm_pkg::PH_CMP: begin
        if (out_load) begin
          phase_nxt = imupm_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = imupm_pkg::PH_IDLE;
    endcase

    lane_ctl.phase  = phase_r;
    lane_ctl.load   = in_fire;
    lane_ctl.primed = primed_r;

    tick_diff = in_ch.sample_tick - prev_tick_r;
    if (primed_r) begin
      intv_nxt = tick_diff[imupm_pkg::INTV_W-1:0];
      ierr_nxt = (intv_nxt < imin_r) || (intv_nxt > imax_r);
    end else begin
      intv_nxt = '0;
      ierr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= imupm_pkg::PH_IDLE;
      alpha_r     <= imupm_pkg::EMA_ALPHA_RST;
      tol_r       <= imupm_pkg::POWER_TOLERANCE_RST;
      imin_r      <= imupm_pkg::INTERVAL_MIN_RST;
      imax_r      <= imupm_pkg::INTERVAL_MAX_RST;
      prev_tick_r <= '0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (cfg_fire) begin
        case (cfg_ch.index)
          imupm_pkg::REG_EMA_ALPHA:       alpha_r <= cfg_ch.data[imupm_pkg::ALPHA_W-1:0];
          imupm_pkg::REG_POWER_TOLERANCE: tol_r   <= cfg_ch.data[imupm_pkg::TOL_W-1:0];
          imupm_pkg::REG_INTERVAL_MIN:    imin_r  <= cfg_ch.data[imupm_pkg::INTV_W-1:0];
          imupm_pkg::REG_INTERVAL_MAX:    imax_r  <= cfg_ch.data[imupm_pkg::INTV_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        prev_tick_r <= in_ch.sample_tick;
      end
      if (out_load) begin
        primed_r    <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      intv_r <= intv_nxt;
      ierr_r <= ierr_nxt;
    end
    if (out_load) begin
      o_mean_r        <= lane_mean;
      o_accel_power_r <= m_accel_power;
      o_gyro_power_r  <= m_gyro_power;
      o_accel_err_r   <= m_accel_err;
      o_gyro_err_r    <= m_gyro_err;
      o_ierr_r        <= ierr_r;
      o_intv_r        <= intv_r;
    end
  end

  for (genvar g = 0; g < NAX; g++) begin : g_lane
    imupm_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .sample  (lane_in[g]),
      .alpha   (alpha_r),
      .mean    (lane_mean[g]),
      .raw_sq  (lane_raw[g]),
      .filt_sq (lane_filt[g])
    );
  end

  imupm_merge #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_merge (
    .clk         (clk),
    .phase       (phase_r),
    .raw_sq      (lane_raw),
    .filt_sq     (lane_filt),
    .tolerance   (tol_r),
    .accel_power (m_accel_power),
    .gyro_power  (m_gyro_power),
    .accel_error (m_accel_err),
    .gyro_error  (m_gyro_err)
  );

  assign out_ch.valid             = out_valid_r;
  assign out_ch.mean_gyro_x       = o_mean_r[imupm_pkg::AX_GYRO_X];
  assign out_ch.mean_gyro_y       = o_mean_r[imupm_pkg::AX_GYRO_Y];
  assign out_ch.mean_gyro_z       = o_mean_r[imupm_pkg::AX_GYRO_Z];
  assign out_ch.mean_accel_x      = o_mean_r[imupm_pkg::AX_ACCEL_X];
  assign out_ch.mean_accel_y      = o_mean_r[imupm_pkg::AX_ACCEL_Y];
  assign out_ch.mean_accel_z      = o_mean_r[imupm_pkg::AX_ACCEL_Z];
  assign out_ch.accel_power       = o_accel_power_r;
  assign out_ch.gyro_power        = o_gyro_power_r;
  assign out_ch.accel_power_error = o_accel_err_r;
  assign out_ch.gyro_power_error  = o_gyro_err_r;
  assign out_ch.interval_error    = o_ierr_r;
  assign out_ch.sample_interval   = o_intv_r;

endmodule

// ===== hw/rtl/imupm_lane.sv =====
// ----------------------------------------------------------------------------
// imupm_lane
// One axis lane: holds the sample and the running mean of one axis and uses
// one shared multiplier for the smoothing product, the raw square and the
// filtered square in successive phases.
// ----------------------------------------------------------------------------
module imupm_lane #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  imupm_pkg::lane_ctl_t               ctl,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample,
  input  logic [imupm_pkg::ALPHA_W-1:0]      alpha,
  output logic signed [SAMPLE_WIDTH-1:0]     mean,
  output logic [2*SAMPLE_WIDTH-1:0]          raw_sq,
  output logic [2*SAMPLE_WIDTH-1:0]          filt_sq
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int OW  = (SW + 1 > imupm_pkg::ALPHA_W + 1) ? SW + 1 : imupm_pkg::ALPHA_W + 1;
  localparam int PW  = 2 * OW;
  localparam int SQW = 2 * SW;

  logic signed [SW-1:0]  x_r;
  logic signed [SW-1:0]  mean_r;
  logic signed [SW-1:0]  mean_nxt;
  logic signed [PW-1:0]  prod_r;
  logic [SQW-1:0]        raw_sq_r;
  logic signed [OW-1:0]  x_ext;
  logic signed [OW-1:0]  mean_ext;
  logic signed [OW-1:0]  alpha_ext;
  logic signed [OW-1:0]  op_a;
  logic signed [OW-1:0]  op_b;
  logic signed [PW-1:0]  shifted;

  assign x_ext     = {{(OW-SW){x_r[SW-1]}}, x_r};
  assign mean_ext  = {{(OW-SW){mean_r[SW-1]}}, mean_r};
  assign alpha_ext = {{(OW-imupm_pkg::ALPHA_W){1'b0}}, alpha};
  assign shifted   = prod_r >>> imupm_pkg::ALPHA_FRAC;

  always_comb begin
    case (ctl.phase)
      imupm_pkg::PH_EMA: begin
        op_a = x_ext - mean_ext;
        op_b = alpha_ext;
      end
      imupm_pkg::PH_RAW: begin
        op_a = x_ext;
        op_b = x_ext;
      end
      default: begin
        op_a = mean_ext;
        op_b = mean_ext;
      end
    endcase
    if (ctl.primed) begin
      mean_nxt = mean_r + shifted[SW-1:0];
    end else begin
      mean_nxt = x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= sample;
    end
    if (ctl.phase == imupm_pkg::PH_RAW) begin
      mean_r <= mean_nxt;
    end
    if (ctl.phase == imupm_pkg::PH_FILT) begin
      raw_sq_r <= prod_r[SQW-1:0];
    end
    if (ctl.phase == imupm_pkg::PH_EMA || ctl.phase == imupm_pkg::PH_RAW ||
        ctl.phase == imupm_pkg::PH_FILT) begin
      prod_r <= op_a * op_b;
    end
  end

  assign mean    = mean_r;
  assign raw_sq  = raw_sq_r;
  assign filt_sq = prod_r[SQW-1:0];

endmodule

// ===== hw/rtl/imupm_merge.sv =====
// ----------------------------------------------------------------------------
// imupm_merge
// Merging stage: adds the squares of the three axes of each sensor, then
// saturates the filtered power and compares raw against filtered power.
// ----------------------------------------------------------------------------
module imupm_merge #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  imupm_pkg::phase_t                phase,
  input  logic [2*SAMPLE_WIDTH-1:0]        raw_sq  [imupm_pkg::AXES],
  input  logic [2*SAMPLE_WIDTH-1:0]        filt_sq [imupm_pkg::AXES],
  input  logic [imupm_pkg::TOL_W-1:0]      tolerance,
  output logic [imupm_pkg::POWER_W-1:0]    accel_power,
  output logic [imupm_pkg::POWER_W-1:0]    gyro_power,
  output logic                             accel_error,
  output logic                             gyro_error
);

  localparam int SQW  = 2 * SAMPLE_WIDTH;
  localparam int SUMW = SQW + 2;
  localparam int EXTW = (SUMW > imupm_pkg::POWER_W + 1) ? SUMW : imupm_pkg::POWER_W + 1;

  logic [SUMW-1:0] raw_g_r;
  logic [SUMW-1:0] raw_a_r;
  logic [SUMW-1:0] filt_g_r;
  logic [SUMW-1:0] filt_a_r;
  logic [EXTW-1:0] raw_g_ext;
  logic [EXTW-1:0] raw_a_ext;
  logic [EXTW-1:0] filt_g_ext;
  logic [EXTW-1:0] filt_a_ext;
  logic [EXTW-1:0] diff_g;
  logic [EXTW-1:0] diff_a;
  logic [EXTW-1:0] tol_ext;
  logic [EXTW-1:0] pmax_ext;

  always_ff @(posedge clk) begin
    if (phase == imupm_pkg::PH_SUM) begin
      raw_g_r  <= SUMW'(raw_sq[imupm_pkg::AX_GYRO_X]) + SUMW'(raw_sq[imupm_pkg::AX_GYRO_Y])
                  + SUMW'(raw_sq[imupm_pkg::AX_GYRO_Z]);
      raw_a_r  <= SUMW'(raw_sq[imupm_pkg::AX_ACCEL_X]) + SUMW'(raw_sq[imupm_pkg::AX_ACCEL_Y])
                  + SUMW'(raw_sq[imupm_pkg::AX_ACCEL_Z]);
      filt_g_r <= SUMW'(filt_sq[imupm_pkg::AX_GYRO_X]) + SUMW'(filt_sq[imupm_pkg::AX_GYRO_Y])
                  + SUMW'(filt_sq[imupm_pkg::AX_GYRO_Z]);
      filt_a_r <= SUMW'(filt_sq[imupm_pkg::AX_ACCEL_X])
                  + SUMW'(filt_sq[imupm_pkg::AX_ACCEL_Y])
                  + SUMW'(filt_sq[imupm_pkg::AX_ACCEL_Z]);
    end
  end

  always_comb begin
    raw_g_ext  = EXTW'(raw_g_r);
    raw_a_ext  = EXTW'(raw_a_r);
    filt_g_ext = EXTW'(filt_g_r);
    filt_a_ext = EXTW'(filt_a_r);
    tol_ext    = EXTW'(tolerance);
    pmax_ext   = EXTW'({imupm_pkg::POWER_W{1'b1}});
    diff_g = (raw_g_ext > filt_g_ext) ? raw_g_ext - filt_g_ext : filt_g_ext - raw_g_ext;
    diff_a = (raw_a_ext > filt_a_ext) ? raw_a_ext - filt_a_ext : filt_a_ext - raw_a_ext;
    gyro_error  = diff_g > tol_ext;
    accel_error = diff_a > tol_ext;
    gyro_power  = (filt_g_ext > pmax_ext) ? {imupm_pkg::POWER_W{1'b1}}
                                          : filt_g_ext[imupm_pkg::POWER_W-1:0];
    accel_power = (filt_a_ext > pmax_ext) ? {imupm_pkg::POWER_W{1'b1}}
                                          : filt_a_ext[imupm_pkg::POWER_W-1:0];
  end

endmodule

// ===== test/ema_power_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ema_power_checker
// Watches the sample, result and configuration channels of the IMU power
// monitor. It keeps its own copy of the registers, the per-axis moving
// averages and the last tick count, and works out the full result of every
// accepted sample. Each result beat is compared field by field with the oldest
// outstanding result. The mismatch count and the number of outstanding results
// go to the testbench top.
// ----------------------------------------------------------------------------
module ema_power_checker
  import imupm_pkg::*;
#(
  parameter int SW = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  imupm_sample_if smp,
  imupm_result_if res,
  imupm_cfg_if    cfg,
  output int      errors,
  output int      outstanding,
  output int      results_checked,
  output int      interval_flags,
  output int      power_flags
);

  typedef struct packed {
    logic [SW-1:0]      mean_gyro_x;
    logic [SW-1:0]      mean_gyro_y;
    logic [SW-1:0]      mean_gyro_z;
    logic [SW-1:0]      mean_accel_x;
    logic [SW-1:0]      mean_accel_y;
    logic [SW-1:0]      mean_accel_z;
    logic [POWER_W-1:0] accel_power;
    logic [POWER_W-1:0] gyro_power;
    logic               accel_power_error;
    logic               gyro_power_error;
    logic               interval_error;
    logic [INTV_W-1:0]  sample_interval;
  } monitor_result_t;

  logic [ALPHA_W-1:0] alpha;
  logic [TOL_W-1:0]   tolerance;
  logic [INTV_W-1:0]  win_lo;
  logic [INTV_W-1:0]  win_hi;
  longint             axis_mean [AXES];
  logic [TICK_W-1:0]  last_tick;
  logic               seen_first;
  monitor_result_t    awaited_results [$];

  function automatic longint power_of(input longint a, input longint b, input longint c);
    return a * a + b * b + c * c;
  endfunction

  function automatic logic [POWER_W-1:0] clip_power(input longint p);
    return (p > longint'({POWER_W{1'b1}})) ? {POWER_W{1'b1}} : POWER_W'(p);
  endfunction

  function automatic logic deviates(input longint raw, input longint filt);
    longint gap;
    gap = (raw > filt) ? raw - filt : filt - raw;
    return gap > longint'(tolerance);
  endfunction

  function automatic monitor_result_t filter_sample(input longint x [AXES],
                                                    input logic [TICK_W-1:0] tick);
    monitor_result_t r;
    longint raw_g, raw_a, filt_g, filt_a;
    logic [TICK_W-1:0] span;
    r = '0;
    for (int i = 0; i < AXES; i++) begin
      if (!seen_first) begin
        axis_mean[i] = x[i];
      end else begin
        axis_mean[i] = axis_mean[i] +
                       (((x[i] - axis_mean[i]) * longint'(alpha)) >>> ALPHA_FRAC);
      end
    end
    if (seen_first) begin
      span = tick - last_tick;
      r.sample_interval = span[INTV_W-1:0];
      r.interval_error = (r.sample_interval < win_lo) || (r.sample_interval > win_hi);
    end
    last_tick = tick;
    seen_first = 1'b1;
    raw_g = power_of(x[AX_GYRO_X], x[AX_GYRO_Y], x[AX_GYRO_Z]);
    raw_a = power_of(x[AX_ACCEL_X], x[AX_ACCEL_Y], x[AX_ACCEL_Z]);
    filt_g = power_of(axis_mean[AX_GYRO_X], axis_mean[AX_GYRO_Y], axis_mean[AX_GYRO_Z]);
    filt_a = power_of(axis_mean[AX_ACCEL_X], axis_mean[AX_ACCEL_Y], axis_mean[AX_ACCEL_Z]);
    r.mean_gyro_x = SW'(axis_mean[AX_GYRO_X]);
    r.mean_gyro_y = SW'(axis_mean[AX_GYRO_Y]);
    r.mean_gyro_z = SW'(axis_mean[AX_GYRO_Z]);
    r.mean_accel_x = SW'(axis_mean[AX_ACCEL_X]);
    r.mean_accel_y = SW'(axis_mean[AX_ACCEL_Y]);
    r.mean_accel_z = SW'(axis_mean[AX_ACCEL_Z]);
    r.accel_power = clip_power(filt_a);
    r.gyro_power = clip_power(filt_g);
    r.accel_power_error = deviates(raw_a, filt_a);
    r.gyro_power_error = deviates(raw_g, filt_g);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      errors++;
    end
  endtask

  task automatic compare_result(input monitor_result_t want);
    check_field("mean_gyro_x", want.mean_gyro_x, $unsigned(res.mean_gyro_x));
    check_field("mean_gyro_y", want.mean_gyro_y, $unsigned(res.mean_gyro_y));
    check_field("mean_gyro_z", want.mean_gyro_z, $unsigned(res.mean_gyro_z));
    check_field("mean_accel_x", want.mean_accel_x, $unsigned(res.mean_accel_x));
    check_field("mean_accel_y", want.mean_accel_y, $unsigned(res.mean_accel_y));
    check_field("mean_accel_z", want.mean_accel_z, $unsigned(res.mean_accel_z));
    check_field("accel_power", want.accel_power, res.accel_power);
    check_field("gyro_power", want.gyro_power, res.gyro_power);
    check_field("accel_power_error", want.accel_power_error, res.accel_power_error);
    check_field("gyro_power_error", want.gyro_power_error, res.gyro_power_error);
    check_field("interval_error", want.interval_error, res.interval_error);
    check_field("sample_interval", want.sample_interval, res.sample_interval);
  endtask

  always @(posedge clk) begin : track
    longint x [AXES];
    monitor_result_t want;
    if (!rst_n) begin
      alpha = EMA_ALPHA_RST;
      tolerance = POWER_TOLERANCE_RST;
      win_lo = INTERVAL_MIN_RST;
      win_hi = INTERVAL_MAX_RST;
      for (int i = 0; i < AXES; i++) begin
        axis_mean[i] = 0;
      end
      last_tick = '0;
      seen_first = 1'b0;
      awaited_results.delete();
      errors = 0;
      results_checked = 0;
      interval_flags = 0;
      power_flags = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat arrived with no sample outstanding");
          errors++;
        end else begin
          want = awaited_results.pop_front();
          compare_result(want);
          results_checked++;
          if (want.interval_error) begin
            interval_flags++;
          end
          if (want.accel_power_error || want.gyro_power_error) begin
            power_flags++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_EMA_ALPHA:       alpha = cfg.data[ALPHA_W-1:0];
          REG_POWER_TOLERANCE: tolerance = cfg.data[TOL_W-1:0];
          REG_INTERVAL_MIN:    win_lo = cfg.data[INTV_W-1:0];
          REG_INTERVAL_MAX:    win_hi = cfg.data[INTV_W-1:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        x[AX_GYRO_X] = longint'(smp.gyro_x);
        x[AX_GYRO_Y] = longint'(smp.gyro_y);
        x[AX_GYRO_Z] = longint'(smp.gyro_z);
        x[AX_ACCEL_X] = longint'(smp.accel_x);
        x[AX_ACCEL_Y] = longint'(smp.accel_y);
        x[AX_ACCEL_Z] = longint'(smp.accel_z);
        awaited_results.push_back(filter_sample(x, smp.sample_tick));
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== test/tb_imu_ema_power_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_imu_ema_power_monitor
// Drives IMU samples and register writes into the moving-average power
// monitor: a directed set covering the first sample, field extremes, tick
// wrap, window edges and extreme register values, then random phases with
// slowly drifting signals, random register settings and changing idle
// patterns on both channels. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_imu_ema_power_monitor;
  import imupm_pkg::*;

  localparam int SW             = 16;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 128;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd4;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [SW-1:0]     gyro_x;
    logic [SW-1:0]     gyro_y;
    logic [SW-1:0]     gyro_z;
    logic [SW-1:0]     accel_x;
    logic [SW-1:0]     accel_y;
    logic [SW-1:0]     accel_z;
    logic [TICK_W-1:0] sample_tick;
  } imu_sample_t;

  logic              clk;
  logic              rst_n;
  int                src_idle_pct;
  int                snk_stall_pct;
  int                hold_reqs = 0;
  int                holds_served = 0;
  int                hold_left = 0;
  int                quiet_cycles = 0;
  int                samples_sent;
  int                settings_used;
  int                axis_level [AXES];
  logic [TICK_W-1:0] cur_tick;
  logic [INTV_W-1:0] win_min;
  logic [INTV_W-1:0] win_max;
  int                mismatch_count;
  int                pending_results;
  int                results_checked;
  int                interval_flags;
  int                power_flags;

  imupm_sample_if #(.SAMPLE_WIDTH(SW)) in_ch();
  imupm_result_if #(.SAMPLE_WIDTH(SW)) out_ch();
  imupm_cfg_if                         cfg_ch();

  imu_ema_power_monitor #(.SAMPLE_WIDTH(SW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ema_power_checker #(.SW(SW)) power_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .smp             (in_ch),
    .res             (out_ch),
    .cfg             (cfg_ch),
    .errors          (mismatch_count),
    .outstanding     (pending_results),
    .results_checked (results_checked),
    .interval_flags  (interval_flags),
    .power_flags     (power_flags)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_reqs) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_imu_ema_power_monitor: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct = 0;
        snk_stall_pct = 0;
      end
      IDLE_SENDER: begin
        src_idle_pct = 85;
        snk_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        src_idle_pct = 0;
        snk_stall_pct = 85;
      end
      default: begin
        src_idle_pct = 22;
        snk_stall_pct = 22;
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic configure(input logic [ALPHA_W-1:0] a, input logic [TOL_W-1:0] tol,
                           input logic [INTV_W-1:0] lo, input logic [INTV_W-1:0] hi,
                           input bit poke_unmapped);
    write_reg(REG_EMA_ALPHA, CFG_DAT_W'(a));
    write_reg(REG_POWER_TOLERANCE, CFG_DAT_W'(tol));
    write_reg(REG_INTERVAL_MIN, CFG_DAT_W'(lo));
    write_reg(REG_INTERVAL_MAX, CFG_DAT_W'(hi));
    if (poke_unmapped) begin
      write_reg(REG_UNMAPPED, {CFG_DAT_W{1'b1}});
    end
    cfg_ch.valid <= 1'b0;
    win_min = lo;
    win_max = hi;
    settings_used++;
  endtask

  task automatic random_setting();
    logic [ALPHA_W-1:0] a;
    logic [TOL_W-1:0]   tol;
    logic [INTV_W-1:0]  lo;
    logic [INTV_W-1:0]  hi;
    case ($urandom_range(3))
      0: a = ALPHA_W'($urandom_range(65535));
      1: a = ALPHA_W'($urandom_range(4096));
      2: a = '1;
      default: a = EMA_ALPHA_RST;
    endcase
    case ($urandom_range(3))
      0: tol = $urandom;
      1: tol = $urandom_range(1 << 20);
      2: tol = '0;
      default: tol = POWER_TOLERANCE_RST;
    endcase
    lo = INTV_W'($urandom_range(20));
    case ($urandom_range(3))
      0: hi = lo + INTV_W'($urandom_range(6));
      1: hi = lo;
      2: hi = INTV_W'($urandom_range(65535));
      default: hi = (lo > 0) ? lo - 1'b1 : '0;
    endcase
    configure(a, tol, lo, hi, 1'b0);
  endtask

  // The sample is only sent from a rising edge; valid stays high after the
  // beat so that back-to-back samples keep a single assignment per edge.
  task automatic send_sample(input imu_sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.gyro_x <= s.gyro_x;
    in_ch.gyro_y <= s.gyro_y;
    in_ch.gyro_z <= s.gyro_z;
    in_ch.accel_x <= s.accel_x;
    in_ch.accel_y <= s.accel_y;
    in_ch.accel_z <= s.accel_z;
    in_ch.sample_tick <= s.sample_tick;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  task automatic push_sample(input int gx, input int gy, input int gz, input int ax,
                             input int ay, input int az, input logic [TICK_W-1:0] step);
    imu_sample_t s;
    cur_tick = cur_tick + step;
    s.gyro_x = SW'(gx);
    s.gyro_y = SW'(gy);
    s.gyro_z = SW'(gz);
    s.accel_x = SW'(ax);
    s.accel_y = SW'(ay);
    s.accel_z = SW'(az);
    s.sample_tick = cur_tick;
    send_sample(s);
  endtask

  // Mostly a slowly moving signal with small noise and ticks near the window,
  // with some full-range values, extremes, level jumps and arbitrary ticks.
  task automatic next_sample(output imu_sample_t s);
    logic [SW-1:0] v [AXES];
    int pick;
    int lvl;
    int lo;
    int hi;
    for (int i = 0; i < AXES; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        lvl = axis_level[i] + int'($urandom_range(512)) - 256;
        if (lvl > 32767) begin
          lvl = 32767;
        end else if (lvl < -32768) begin
          lvl = -32768;
        end
        v[i] = SW'(lvl);
      end else if (pick < 80) begin
        v[i] = SW'($urandom);
      end else if (pick < 90) begin
        v[i] = pick[0] ? {1'b0, {(SW-1){1'b1}}} : {1'b1, {(SW-1){1'b0}}};
      end else begin
        axis_level[i] = int'($urandom_range(65535)) - 32768;
        v[i] = SW'(axis_level[i]);
      end
    end
    if ($urandom_range(99) < 8) begin
      cur_tick = $urandom;
    end else if (win_min > win_max) begin
      cur_tick = cur_tick + $urandom_range(40);
    end else begin
      lo = (win_min >= 2) ? int'(win_min) - 2 : 0;
      hi = (int'(win_max) + 2 > 65535) ? 65535 : int'(win_max) + 2;
      cur_tick = cur_tick + $urandom_range(hi, lo);
    end
    s.gyro_x = v[AX_GYRO_X];
    s.gyro_y = v[AX_GYRO_Y];
    s.gyro_z = v[AX_GYRO_Z];
    s.accel_x = v[AX_ACCEL_X];
    s.accel_y = v[AX_ACCEL_Y];
    s.accel_z = v[AX_ACCEL_Z];
    s.sample_tick = cur_tick;
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic drain();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_burst(input int count);
    imu_sample_t s;
    for (int n = 0; n < count; n++) begin
      next_sample(s);
      send_sample(s);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.gyro_x = '0;
    in_ch.gyro_y = '0;
    in_ch.gyro_z = '0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    in_ch.sample_tick = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    samples_sent = 0;
    settings_used = 1;
    cur_tick = '0;
    win_min = INTERVAL_MIN_RST;
    win_max = INTERVAL_MAX_RST;
    for (int i = 0; i < AXES; i++) begin
      axis_level[i] = 0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle(IDLE_NONE);
    cur_tick = 32'hFFFF_FFF6;
    push_sample(-32768, -32768, -32768, -32768, -32768, -32768, 0);
    push_sample(32767, 32767, 32767, 32767, 32767, 32767, 9);
    push_sample(0, 0, 0, 0, 0, 0, 11);
    push_sample(21845, 21845, 21845, 21845, 21845, 21845, 8);
    push_sample(-21846, -21846, -21846, -21846, -21846, -21846, 12);
    push_sample(32767, -32768, 0, -1, 1, 256, 10);
    push_sample(-1, -1, -1, -1, -1, -1, 32'h0001_000A);
    push_sample(256, 0, -256, 0, 0, 0, 32'h8000_000A);
    push_sample(0, 0, 0, 256, 0, 0, 10);
    drain();

    configure('1, '0, '0, '1, 1'b1);
    push_sample(32767, 32767, 32767, 32767, 32767, 32767, 0);
    push_sample(-32768, -32768, -32768, -32768, -32768, -32768, 32'h0000_FFFF);
    random_burst(3);
    drain();

    configure('0, '1, 16'd20, 16'd5, 1'b0);
    random_burst(4);
    drain();

    configure(16'd1, 32'd1, '0, '0, 1'b0);
    push_sample(100, -100, 300, -300, 500, -500, 0);
    push_sample(-100, 100, -300, 300, -500, 500, 1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        configure(EMA_ALPHA_RST, POWER_TOLERANCE_RST, INTERVAL_MIN_RST, INTERVAL_MAX_RST,
                  1'b0);
      end else begin
        random_setting();
      end
      set_idle(idle_mode_t'(p % 4));
      if (p == 0) begin
        random_burst(40);
        hold_reqs++;
        random_burst(PHASE_ITEMS - 40);
      end else if (p == 4) begin
        random_burst(PHASE_ITEMS / 2);
        wait_results();
        random_burst(PHASE_ITEMS / 2);
      end else begin
        random_burst(PHASE_ITEMS);
      end
      drain();
    end

    $display("Sent %0d samples through %0d register settings under four idle patterns.",
             samples_sent, settings_used);
    $display("Checked %0d results: %0d with an interval flag, %0d with a power flag.",
             results_checked, interval_flags, power_flags);
    if (mismatch_count == 0) begin
      $display("tb_imu_ema_power_monitor: done, clean");
    end else begin
      $display("tb_imu_ema_power_monitor: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/imupm_pkg.sv
hw/rtl/imupm_if.sv
hw/rtl/imupm_lane.sv
hw/rtl/imupm_merge.sv
hw/rtl/imu_ema_power_monitor.sv
test/ema_power_checker.sv
test/tb_imu_ema_power_monitor.sv
